>>> src/text_console_cell_writer_assert.svh
// assertion helpers for the console cell writer
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked while out of reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int NUM_W       = 32;
   localparam int ADDR_W      = 11;
   localparam int VALUE_W     = 16;
   localparam int DIGIT_W     = 4;
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_IDX_W = 4;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;
   localparam logic [CHAR_W-1:0] CH_ZERO      = 8'd48;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd31;

   localparam logic [0:0] CMD_PUT_CHAR  = 1'b0;
   localparam logic [0:0] CMD_PUT_NUMBER = 1'b1;

   // n / 10 == (n * 0xCCCCCCCD) >> 35 for every 32-bit n
   localparam logic [NUM_W-1:0] DIV_RECIP = 32'hCCCC_CCCD;
   localparam int               DIV_SHIFT = 35;

   typedef struct packed {
      logic [NUM_W-1:0]   quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_result_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

`default_nettype wire

>>> src/tcw_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcw_req_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [CHAR_W-1:0] char_code;
   logic [NUM_W-1:0]  number;

   modport source (output valid, output command, output char_code, output number,
                   input ready);
   modport sink   (input valid, input command, input char_code, input number,
                   output ready);
endinterface

`default_nettype wire

>>> src/tcw_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcw_rsp_if import tcw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  cell_address;
   logic [VALUE_W-1:0] cell_value;
   logic               last;

   modport source (output valid, output cell_address, output cell_value, output last,
                   input ready);
   modport sink   (input valid, input cell_address, input cell_value, input last,
                   output ready);
endinterface

`default_nettype wire

>>> src/tcw_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcw_csr_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] attribute;

   modport source (output valid, output attribute, input ready);
   modport sink   (input valid, input attribute, output ready);
endinterface

`default_nettype wire

>>> src/text_console_cell_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   port     dir  payload
// -------   ------   ---  ----------------------------------------
// request   req_ch   in   command, char_code, number
// response  rsp_ch   out  cell_address, cell_value, last
// control   csr_ch   in   attribute (always ready)
//
// a character item is taken while idle and written via the emit state and
// response register; a newline moves the cursor only; a number item is split
// by the divide-by-ten multiplier, digits written most significant first
// request ready is high only while no item is at work
// a stalled response holds the sequencer; reset is synchronous and clears the
// cursor, the sequencer and the attribute (31)
module text_console_cell_writer import tcw_pkg::*; #(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROWS    = DEFAULT_ROWS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch,
   tcw_csr_if.sink    csr_ch
);

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int FULL_W = (ROW_W + COL_W > ADDR_W) ? ROW_W + COL_W : ADDR_W;

   state_type               state_ff, state_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [ATTR_W-1:0]       attr_ff;
   logic [CHAR_W-1:0]       char_ff, char_in;
   logic                    is_num_ff, is_num_in;
   logic                    advance_ff, advance_in;
   logic [DIGIT_W-1:0]      digits_ff [MAX_DIGITS];
   logic [DIGIT_IDX_W-1:0]  count_ff, count_in;
   logic [DIGIT_IDX_W-1:0]  idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    div_start;
   logic [NUM_W-1:0]        div_dividend;
   div_result_type          div_result;
   logic                    digit_we;
   logic                    slot_free;
   logic                    emit_go;
   logic [COL_W-1:0]        col_adv;
   logic [ROW_W-1:0]        row_next;
   logic [ROW_W-1:0]        row_adv;
   logic [CHAR_W-1:0]       emit_char;
   logic [FULL_W-1:0]       addr_full;

   tcw_div10 u_div (
      .clock    (clock),
      .start    (div_start),
      .dividend (div_dividend),
      .result   (div_result)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit_go   = (state_ff == ST_EMIT) && slot_free;

   assign row_next = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
   assign col_adv  = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + 1'b1;
   assign row_adv  = (col_ff == COL_W'(COLUMNS - 1)) ? row_next : row_ff;

   assign emit_char = is_num_ff ? CH_ZERO + CHAR_W'(digits_ff[idx_ff]) : char_ff;
   assign addr_full = FULL_W'(row_ff) * FULL_W'(COLUMNS) + FULL_W'(col_ff);

   assign rsp_addr_in  = addr_full[ADDR_W-1:0];
   assign rsp_value_in = {attr_ff, emit_char};
   assign rsp_last_in  = is_num_ff ? (idx_ff == '0) : 1'b1;
   assign rsp_valid_in = emit_go ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      char_in      = char_ff;
      is_num_in    = is_num_ff;
      advance_in   = advance_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      div_start    = 1'b0;
      div_dividend = req_ch.number;
      digit_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.command == CMD_PUT_NUMBER) begin
                  div_start  = 1'b1;
                  count_in   = '0;
                  is_num_in  = 1'b1;
                  advance_in = 1'b1;
                  state_in   = ST_DIV;
               end else if (req_ch.char_code == CH_NEWLINE) begin
                  col_in = '0;
                  row_in = row_next;
               end else if (req_ch.char_code == CH_BACKSPACE) begin
                  if (col_ff != '0) begin
                     col_in = col_ff - 1'b1;
                  end
                  char_in    = CH_BLANK;
                  is_num_in  = 1'b0;
                  advance_in = 1'b0;
                  state_in   = ST_EMIT;
               end else begin
                  char_in    = req_ch.char_code;
                  is_num_in  = 1'b0;
                  advance_in = 1'b1;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            // digits land least significant first
            digit_we = 1'b1;
            count_in = count_ff + 1'b1;
            if (div_result.quotient == '0) begin
               idx_in   = count_ff;
               state_in = ST_EMIT;
            end else begin
               div_start    = 1'b1;
               div_dividend = div_result.quotient;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               if (advance_ff) begin
                  col_in = col_adv;
                  row_in = row_adv;
               end
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            attr_ff <= csr_ch.attribute;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      is_num_ff  <= is_num_in;
      advance_ff <= advance_in;
      count_ff   <= count_in;
      idx_ff     <= idx_in;
      if (digit_we) begin
         digits_ff[count_ff] <= div_result.remainder;
      end
      if (emit_go) begin
         rsp_addr_ff  <= rsp_addr_in;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.cell_address = rsp_addr_ff;
   assign rsp_ch.cell_value   = rsp_value_ff;
   assign rsp_ch.last         = rsp_last_ff;

`include "text_console_cell_writer_assert.svh"

   `TCW_ASSERT_IMPLY(a_col_range, 1'b1, col_ff <= COL_W'(COLUMNS - 1), "column out of range")
   `TCW_ASSERT_IMPLY(a_row_range, 1'b1, row_ff <= ROW_W'(ROWS - 1), "row out of range")
   `TCW_ASSERT_IMPLY(a_digit_count, state_ff == ST_DIV, count_ff < DIGIT_IDX_W'(MAX_DIGITS), "too many digits")
   `TCW_ASSERT_NEXT(a_last_ends, emit_go && rsp_last_in, state_ff == ST_IDLE, "item not closed after last write")

endmodule

`default_nettype wire

>>> src/tcw_div10.sv
`timescale 1ns / 1ps
`default_nettype none

// one divide-by-ten step: reciprocal product and dividend registered on start; quotient
// and remainder both follow combinationally from those registers in the next cycle
module tcw_div10 import tcw_pkg::*; (
   input  wire logic             clock,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   output div_result_type        result
);

   logic [2*NUM_W-1:0] product_ff;
   logic [2*NUM_W-1:0] product_in;
   logic [NUM_W-1:0]   dividend_ff;
   logic [NUM_W-1:0]   dividend_in;
   logic [NUM_W-1:0]   quotient;
   logic [NUM_W-1:0]   diff;

   always_comb begin
      product_in  = product_ff;
      dividend_in = dividend_ff;
      if (start) begin
         product_in  = {{NUM_W{1'b0}}, dividend} * {{NUM_W{1'b0}}, DIV_RECIP};
         dividend_in = dividend;
      end
   end

   always_ff @(posedge clock) begin
      product_ff  <= product_in;
      dividend_ff <= dividend_in;
   end

   assign quotient = NUM_W'(product_ff >> DIV_SHIFT);
   // q * 10 as (q << 3) + (q << 1); the difference is below ten
   assign diff     = dividend_ff - (quotient << 3) - (quotient << 1);

   assign result.quotient  = quotient;
   assign result.remainder = diff[DIGIT_W-1:0];

endmodule

`default_nettype wire
